// ===== hdl/kvtrs_pkg.sv =====
// ----------------------------------------------------------------------------
// kvtrs_pkg - shared types and constants for the key/value table
// Widths, operation codes and the per-cell entry and command structs.
// ----------------------------------------------------------------------------
`default_nettype none

package kvtrs_pkg;

  localparam int unsigned CAPACITY   = 16;
  localparam int unsigned KEY_BITS   = 32;
  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned MODE_BITS  = 3;
  localparam int unsigned RANK_BITS  = 8;
  localparam int unsigned IDX_W      = $clog2(CAPACITY);
  localparam int unsigned CNT_W      = $clog2(CAPACITY + 1);

  // input word: mode, key, value, rank packed from bit 0, padded to bytes
  localparam int unsigned IN_BITS    = MODE_BITS + KEY_BITS + VALUE_BITS + RANK_BITS;
  localparam int unsigned IN_W       = ((IN_BITS + 7) / 8) * 8;
  // output word: ok, key_out, value_out, entry_total
  localparam int unsigned OUT_BITS   = 1 + KEY_BITS + VALUE_BITS + CNT_W;
  localparam int unsigned OUT_W      = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_INSERT     = 3'd0,
    MODE_UPDATE     = 3'd1,
    MODE_INS_OR_UPD = 3'd2,
    MODE_ERASE      = 3'd3,
    MODE_LOOKUP     = 3'd4,
    MODE_RANK_SEL   = 3'd5
  } mode_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic                  valid;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } entry_t;

  // broadcast to every cell in the execute cycle
  typedef struct packed {
    logic                  ins;
    logic                  upd;
    logic                  ers;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/kvtrs_cell.sv =====
// ----------------------------------------------------------------------------
// kvtrs_cell - one slot of the sorted key/value chain
// Holds one entry, compares it with the broadcast key and shifts left/right.
// ----------------------------------------------------------------------------
`default_nettype none

module kvtrs_cell
  import kvtrs_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire cell_cmd_t cmd_i,
  input  wire logic      left_lt_i,   // neighbour below holds a smaller key
  input  wire entry_t    left_i,
  input  wire entry_t    right_i,
  output entry_t         entry_o,
  output logic           lt_o,
  output logic           eq_o
);

  logic                  valid_q, valid_d;
  logic [KEY_BITS-1:0]   key_q, key_d;
  logic [VALUE_BITS-1:0] value_q, value_d;

  assign lt_o    = valid_q && (key_q < cmd_i.key);
  assign eq_o    = valid_q && (key_q == cmd_i.key);
  assign entry_o = '{valid: valid_q, key: key_q, value: value_q};

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    value_d = value_q;
    priority if (cmd_i.ins && !lt_o) begin
      if (left_lt_i) begin
        valid_d = 1'b1;
        key_d   = cmd_i.key;
        value_d = cmd_i.value;
      end else begin
        valid_d = left_i.valid;
        key_d   = left_i.key;
        value_d = left_i.value;
      end
    end else if (cmd_i.ers && !lt_o) begin
      // close the gap: everything from the erased key upward moves down
      valid_d = right_i.valid;
      key_d   = right_i.key;
      value_d = right_i.value;
    end else if (cmd_i.upd && eq_o) begin
      value_d = cmd_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
  end

endmodule

`default_nettype wire

// ===== hdl/key_value_table_with_rank_select.sv =====
// ----------------------------------------------------------------------------
// key_value_table_with_rank_select - sorted key/value table, 16 entries
// Stream in one operation word, stream out one result word per operation.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel (s_axis_*) takes one operation word: mode, key, value, rank.
//   Master channel (m_axis_*) gives one result word per operation: ok,
//   key_out, value_out and entry_total (count after the operation).
//   Entries live in a chain of cells kept sorted by unsigned key, valid
//   entries packed from cell 0. Insert shifts the cells above the insertion
//   point up by one; erase shifts them down by one. Lookup and update use a
//   parallel key match; rank select reads cell number rank directly.
// Timing:
//   A word is taken while tready is high and executed in the execute state,
//   where the whole chain updates at once and the result is loaded into the
//   output register. The result word is valid on the master side from the edge
//   that ends the execute state. tready is high only between operations, set
//   by the accept/execute sequencer.
// Stalls:
//   A waiting result does not block the next word from being taken; the
//   execute cycle waits until the output register is empty or being read.
// Reset:
//   rst_ni clears all valid flags, the entry count and both channels.
//   No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module key_value_table_with_rank_select
  import kvtrs_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // [2:0] mode, [34:3] key, [66:35] value, [74:67] rank, rest zero
  input  wire logic [IN_W-1:0]  s_axis_tdata_i,
  output logic                  m_axis_tvalid_o,
  input  wire logic             m_axis_tready_i,
  // [0] ok, [32:1] key_out, [64:33] value_out, [69:65] entry_total, rest zero
  output logic [OUT_W-1:0]      m_axis_tdata_o
);

  localparam int unsigned KEY_LO   = MODE_BITS;
  localparam int unsigned VALUE_LO = KEY_LO + KEY_BITS;
  localparam int unsigned RANK_LO  = VALUE_LO + VALUE_BITS;

  // sequencer
  state_e state_q, state_d;
  logic   exec_go;

  // operand register
  logic [MODE_BITS-1:0]  mode_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] value_q;
  logic [RANK_BITS-1:0]  rank_q;
  logic                  s_take;

  // table state
  logic [CNT_W-1:0] count_q, count_d;
  cell_cmd_t        cmd;
  entry_t           cells [CAPACITY];
  logic [CAPACITY-1:0] lt_w, eq_w;
  logic             hit, full;
  logic [VALUE_BITS-1:0] hit_value;

  // result register
  logic                  out_valid_q;
  logic                  ok_q, ok_d;
  logic [KEY_BITS-1:0]   key_out_q, key_out_d;
  logic [VALUE_BITS-1:0] value_out_q, value_out_d;
  logic [CNT_W-1:0]      total_q;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_take          = s_axis_tvalid_i && s_axis_tready_o;
  assign exec_go         = (state_q == ST_EXEC) && (!out_valid_q || m_axis_tready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (s_take)  state_d = ST_EXEC;
      ST_EXEC: if (exec_go) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_take) begin
      mode_q  <= s_axis_tdata_i[MODE_BITS-1:0];
      key_q   <= s_axis_tdata_i[KEY_LO +: KEY_BITS];
      value_q <= s_axis_tdata_i[VALUE_LO +: VALUE_BITS];
      rank_q  <= s_axis_tdata_i[RANK_LO +: RANK_BITS];
    end
  end

  // match summary over the chain
  assign hit  = |eq_w;
  assign full = cells[CAPACITY-1].valid;

  always_comb begin
    hit_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_value = hit_value | (eq_w[i] ? cells[i].value : '0);
    end
  end

  // decode the operation against the current table
  always_comb begin
    cmd         = '{ins: 1'b0, upd: 1'b0, ers: 1'b0, key: key_q, value: value_q};
    count_d     = count_q;
    ok_d        = 1'b0;
    key_out_d   = '0;
    value_out_d = '0;
    unique case (mode_q)
      MODE_INSERT, MODE_INS_OR_UPD: begin
        if (hit) begin
          if (mode_q == MODE_INS_OR_UPD) begin
            cmd.upd = exec_go;
            ok_d    = 1'b1;
          end
        end else if (!full) begin
          cmd.ins = exec_go;
          count_d = count_q + 1'b1;
          ok_d    = 1'b1;
        end
      end
      MODE_UPDATE: begin
        cmd.upd = exec_go && hit;
        ok_d    = hit;
      end
      MODE_ERASE: begin
        cmd.ers = exec_go && hit;
        ok_d    = hit;
        if (hit) count_d = count_q - 1'b1;
      end
      MODE_LOOKUP: begin
        ok_d        = hit;
        value_out_d = hit_value;
      end
      MODE_RANK_SEL: begin
        // chain is sorted and packed, so rank r sits in cell r
        if (rank_q < {{(RANK_BITS-CNT_W){1'b0}}, count_q}) begin
          ok_d        = 1'b1;
          key_out_d   = cells[rank_q[IDX_W-1:0]].key;
          value_out_d = cells[rank_q[IDX_W-1:0]].value;
        end
      end
      default: ;
    endcase
  end

  // the chain itself
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic   left_lt;
    entry_t left_e, right_e;
    if (i == 0) begin : g_first
      assign left_lt = 1'b1;
      assign left_e  = '0;
    end else begin : g_mid
      assign left_lt = lt_w[i-1];
      assign left_e  = cells[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_e = '0;
    end else begin : g_inner
      assign right_e = cells[i+1];
    end

    kvtrs_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd),
      .left_lt_i (left_lt),
      .left_i    (left_e),
      .right_i   (right_e),
      .entry_o   (cells[i]),
      .lt_o      (lt_w[i]),
      .eq_o      (eq_w[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (exec_go) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_go) begin
      ok_q        <= ok_d;
      key_out_q   <= key_out_d;
      value_out_q <= value_out_d;
      total_q     <= count_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_W-OUT_BITS){1'b0}}, total_q, value_out_q, key_out_q, ok_q};

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench - self-checking bench for key_value_table_with_rank_select
// Streams table operations into the block under random idling on both sides,
// predicts every result word from its own copy of the table and checks the
// result stream field by field, in order.
// ----------------------------------------------------------------------------

module testbench;
  import kvtrs_pkg::*;

  // modes 6 and 7 are not operations; the block must answer them as no-ops
  localparam logic [MODE_BITS-1:0] MODE_SPARE_LO = 3'd6;
  localparam logic [MODE_BITS-1:0] MODE_SPARE_HI = 3'd7;

  localparam int unsigned RANDOM_WORDS = 650;
  localparam int unsigned HOLD_AT      = 200;  // receiver holds off from here
  localparam int unsigned HOLD_CYCLES  = 60;
  localparam int unsigned DRAIN_AT     = 420;  // sender waits for all results here
  localparam int unsigned QUIET_FROM   = 560;  // no idling from here on
  localparam int unsigned POOL_SIZE    = 20;   // a few more keys than the table holds
  localparam int unsigned REPORT_MAX   = 10;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  // field order matches the word layout, lowest bits last
  typedef struct packed {
    logic [RANK_BITS-1:0]  rank;
    logic [VALUE_BITS-1:0] value;
    logic [KEY_BITS-1:0]   key;
    logic [MODE_BITS-1:0]  mode;
  } kv_op_t;

  typedef struct packed {
    logic [CNT_W-1:0]             total;
    logic signed [VALUE_BITS-1:0] value_out;
    logic [KEY_BITS-1:0]          key_out;
    logic                         ok;
  } kv_result_t;

  // Shadow table plus the queue of results still owed by the block.
  class kv_scoreboard;
    logic                  slot_used [CAPACITY];
    logic [KEY_BITS-1:0]   slot_key  [CAPACITY];
    logic [VALUE_BITS-1:0] slot_val  [CAPACITY];
    int unsigned           entries;
    kv_result_t            owed_q[$];
    int unsigned           errors;

    function new();
      foreach (slot_used[i]) begin
        slot_used[i] = 1'b0;
        slot_key[i]  = '0;
        slot_val[i]  = '0;
      end
      entries = 0;
      errors  = 0;
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    // apply one accepted operation to the shadow table, queue its result
    function void note_op(kv_op_t op);
      kv_result_t  exp;
      int          hit;
      int          spot;
      int unsigned below;
      exp  = '0;
      hit  = -1;
      spot = -1;
      for (int i = 0; i < CAPACITY; i++) begin
        if (hit < 0 && slot_used[i] && slot_key[i] == op.key) hit = i;
        if (spot < 0 && !slot_used[i]) spot = i;
      end
      case (op.mode)
        MODE_INSERT, MODE_INS_OR_UPD: begin
          if (hit >= 0) begin
            if (op.mode == MODE_INS_OR_UPD) begin
              slot_val[hit] = op.value;
              exp.ok = 1'b1;
            end
          end else if (spot >= 0) begin
            slot_used[spot] = 1'b1;
            slot_key[spot]  = op.key;
            slot_val[spot]  = op.value;
            entries++;
            exp.ok = 1'b1;
          end
        end
        MODE_UPDATE: begin
          if (hit >= 0) begin
            slot_val[hit] = op.value;
            exp.ok = 1'b1;
          end
        end
        MODE_ERASE: begin
          if (hit >= 0) begin
            slot_used[hit] = 1'b0;
            entries--;
            exp.ok = 1'b1;
          end
        end
        MODE_LOOKUP: begin
          if (hit >= 0) begin
            exp.value_out = slot_val[hit];
            exp.ok = 1'b1;
          end
        end
        MODE_RANK_SEL: begin
          // keys are unique, so exactly one entry has rank keys below it
          if (op.rank < entries) begin
            for (int i = 0; i < CAPACITY; i++) begin
              if (slot_used[i] && !exp.ok) begin
                below = 0;
                for (int j = 0; j < CAPACITY; j++)
                  if (slot_used[j] && slot_key[i] > slot_key[j]) below++;
                if (below == op.rank) begin
                  exp.key_out   = slot_key[i];
                  exp.value_out = slot_val[i];
                  exp.ok        = 1'b1;
                end
              end
            end
          end
        end
        default: ;
      endcase
      exp.total = CNT_W'(entries);
      owed_q.push_back(exp);
    endfunction

    function void check_result(kv_result_t got);
      kv_result_t exp;
      if (owed_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("mismatch: result with none owed: ok=%0b key=%h value=%0d total=%0d",
                   got.ok, got.key_out, got.value_out, got.total);
        return;
      end
      exp = owed_q.pop_front();
      if (got.ok !== exp.ok || got.key_out !== exp.key_out ||
          got.value_out !== exp.value_out || got.total !== exp.total) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display({"mismatch: exp ok=%0b key=%h value=%0d total=%0d,",
                    " got ok=%0b key=%h value=%0d total=%0d"},
                   exp.ok, exp.key_out, exp.value_out, exp.total,
                   got.ok, got.key_out, got.value_out, got.total);
      end
    endfunction

    function void finish();
      if (owed_q.size() != 0) begin
        errors += owed_q.size();
        $display("mismatch: %0d results never arrived", owed_q.size());
      end
    endfunction
  endclass

  logic             clk_i          = 1'b0;
  logic             rst_n          = 1'b0;
  logic             s_axis_tvalid  = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata   = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready  = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  logic             hold_off_req   = 1'b0;  // set by stimulus, cleared by receiver
  logic             quiet_phase    = 1'b0;
  int unsigned      cycle_count    = 0;
  kv_scoreboard     sb;

  key_value_table_with_rank_select dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result words are taken at the edge where tvalid and tready are both high
  always @(posedge clk_i) begin
    if (rst_n && m_axis_tvalid && m_axis_tready)
      sb.check_result(kv_result_t'(m_axis_tdata[OUT_BITS-1:0]));
  end

  // receiver: random stall bursts, one long hold-off on request, none at the end
  initial begin : receiver
    wait (rst_n);
    forever begin
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else if (quiet_phase) begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end else if ($urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  // offer one operation word and hold it until taken; tvalid stays high
  task automatic issue(input logic [MODE_BITS-1:0] mode, input logic [KEY_BITS-1:0] key,
                       input logic [VALUE_BITS-1:0] value, input logic [RANK_BITS-1:0] rank);
    kv_op_t op;
    op.mode  = mode;
    op.key   = key;
    op.value = value;
    op.rank  = rank;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'(op);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_op(op);
  endtask

  task automatic pause_sender(input int unsigned cycles);
    s_axis_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // sampled away from the active edge so the monitor has settled
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic [KEY_BITS-1:0]   key_pool [POOL_SIZE];
    logic [MODE_BITS-1:0]  mode;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
    logic [RANK_BITS-1:0]  rank;
    int unsigned           roll;
    int unsigned           ins_w;
    int unsigned           ers_w;

    sb = new();
    foreach (key_pool[i]) key_pool[i] = $urandom;
    key_pool[0] = '0;
    key_pool[1] = '1;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'h7fff_ffff;

    repeat (6) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, extremes, duplicates, no-op modes, full table
    issue(MODE_LOOKUP,     '0,           '0,           '0);
    issue(MODE_RANK_SEL,   '0,           '0,           '0);
    issue(MODE_ERASE,      32'h5,        '0,           '0);
    issue(MODE_UPDATE,     32'h5,        32'h1234,     '0);
    issue(MODE_INS_OR_UPD, '0,           32'h8000_0000, '0);
    issue(MODE_INSERT,     '1,           32'h7fff_ffff, '0);
    issue(MODE_INSERT,     '0,           32'h1,        '0);
    issue(MODE_UPDATE,     '1,           '1,           '0);
    issue(MODE_INS_OR_UPD, '0,           '0,           '0);
    issue(MODE_LOOKUP,     '1,           '0,           '0);
    issue(MODE_RANK_SEL,   '0,           '0,           8'd1);
    issue(MODE_RANK_SEL,   '0,           '0,           '1);
    issue(MODE_SPARE_LO,   $urandom,     $urandom,     RANK_BITS'($urandom));
    issue(MODE_SPARE_HI,   $urandom,     $urandom,     RANK_BITS'($urandom));
    for (int i = 0; i < CAPACITY - 2; i++)
      issue(MODE_INSERT, 32'h1 << i, $urandom, '0);
    issue(MODE_INSERT,     32'h5555_aaaa, $urandom,    '0);
    issue(MODE_INS_OR_UPD, 32'haaaa_5555, $urandom,    '0);
    issue(MODE_RANK_SEL,   '0,           '0,           8'd15);
    issue(MODE_ERASE,      '0,           '0,           '0);
    wait_drained();

    // random: pool keys so hits and a full table are common, stray keys as noise
    for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
      if (n == HOLD_AT)    hold_off_req = 1'b1;
      if (n == DRAIN_AT)   wait_drained();
      if (n == QUIET_FROM) quiet_phase = 1'b1;
      if (!quiet_phase && $urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 7));

      // alternate between filling and emptying the table
      ins_w = ((n / 80) % 2 == 1) ? 10 : 30;
      ers_w = ((n / 80) % 2 == 1) ? 35 : 10;
      roll  = $urandom_range(0, 99);
      if (roll < ins_w)                    mode = MODE_INSERT;
      else if (roll < ins_w + 10)          mode = MODE_UPDATE;
      else if (roll < ins_w + 25)          mode = MODE_INS_OR_UPD;
      else if (roll < ins_w + 25 + ers_w)  mode = MODE_ERASE;
      else if (roll < ins_w + 40 + ers_w)  mode = MODE_LOOKUP;
      else if (roll < 97)                  mode = MODE_RANK_SEL;
      else                                 mode = $urandom_range(0, 1) ? MODE_SPARE_HI
                                                                       : MODE_SPARE_LO;

      key = ($urandom_range(0, 19) == 0) ? $urandom
                                         : key_pool[$urandom_range(0, POOL_SIZE - 1)];
      case ($urandom_range(0, 9))
        0:       value = 32'h8000_0000;
        1:       value = 32'h7fff_ffff;
        2:       value = '0;
        3:       value = '1;
        default: value = $urandom;
      endcase
      rank = ($urandom_range(0, 4) == 0) ? RANK_BITS'($urandom_range(0, 255))
                                         : RANK_BITS'($urandom_range(0, 17));
      issue(mode, key, value, rank);
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    sb.finish();
    if (sb.errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
